// ----- hw/rtl/pidpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pidpm_pkg
// shared codes, pipeline types and saturating arithmetic for the pid
// position motor controller
// ----------------------------------------------------------------------------
package pidpm_pkg;

    localparam int POS_W_MAX      = 32;
    localparam int SUM_W_MAX      = 64;
    localparam int POS_WIDTH_DEF  = 32;
    localparam int SUM_WIDTH_DEF  = 48;
    localparam int DEADBAND       = 5;
    localparam logic [15:0] MAX_DUTY_RESET = 16'd100;

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0001;

    // item commands
    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_TARGET = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // step and drive directions
    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_STOP = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_KP         = 2'd0;
    localparam logic [1:0] CFG_KI_DT      = 2'd1;
    localparam logic [1:0] CFG_KD_OVER_DT = 2'd2;
    localparam logic [1:0] CFG_MAX_DUTY   = 2'd3;

    typedef struct packed {
        logic                   is_tick;
        logic [1:0]             dir;
        logic                   err_lt_db;
        logic [POS_W_MAX-1:0]   pos;
        logic [POS_W_MAX-1:0]   err_mag;
    } meta_t;

    typedef struct packed {
        meta_t                  meta;
        logic [POS_W_MAX-1:0]   err;
        logic [POS_W_MAX-1:0]   dmag;
        logic                   dneg;
        logic [SUM_W_MAX-1:0]   sum;
    } op_t;

    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
    } gains_t;

    typedef struct packed {
        meta_t              meta;
        logic signed [63:0] acc;
    } acc_t;

    function automatic logic [31:0] abs32(input logic [31:0] g);
        return g[31] ? (~g + 32'd1) : g;
    endfunction

    // combine partial products of a magnitude, clamp and apply the sign
    function automatic logic [63:0] sat_finish(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input logic        neg);
        logic [63:0] m;
        logic [64:0] s;
        s = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
        if (hi >= 64'h0000_0000_8000_0000)
            m = SAT_MAX;
        else if (s > {1'b0, SAT_MAX})
            m = SAT_MAX;
        else
            m = s[63:0];
        return neg ? (~m + 64'd1) : m;
    endfunction

    // symmetric saturating add
    function automatic logic [63:0] sat_add(input logic [63:0] a,
                                            input logic [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, SAT_MAX}))
            return SAT_MAX;
        else if (s < $signed({1'b1, SAT_MIN}))
            return SAT_MIN;
        else
            return s[63:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pidpm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pidpm_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface pidpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  step_dir;
    logic [31:0] target;

    modport source (output valid, output cmd, output step_dir, output target,
                    input ready);
    modport sink   (input valid, input cmd, input step_dir, input target,
                    output ready);
endinterface

interface pidpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty;
    logic [1:0]  direction;
    logic [31:0] position;
    logic [31:0] error_mag;

    modport source (output valid, output duty, output direction, output position,
                    output error_mag, input ready);
    modport sink   (input valid, input duty, input direction, input position,
                    input error_mag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pid_position_motor_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_position_motor_control
// pid position controller with deadband and duty limit, Q16.16 gains
// ----------------------------------------------------------------------------
// usage
//   req carries command items: encoder step, new target or control tick.
//   rsp carries one result item per command item, in order: duty and
//   direction of the latest control tick, position and error after the item.
//   the user must write gains and duty limit on cfg only while idle, which
//   is unchecked; the write takes effect at the edge where cfg_we is high.
// timing
//   one item per cycle sustained while rsp is not held; an accepted item
//   passes stage 1, the mac and the output stage before it shows on rsp.
//   the rate rests on updating position, error and integral at acceptance;
//   the multiplies, clamps and sums run behind it in four pipeline stages.
// reset
//   rst_n clears position, goal, error, integral, duty and all valid bits;
//   gains reset to zero, duty limit to 100, direction to up.
// stall
//   when rsp is held, each stage keeps its item and bubbles are squeezed
//   out; req.ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module pid_position_motor_control
    import pidpm_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    pidpm_req_if.sink        req,
    pidpm_rsp_if.source      rsp
);

    // configuration
    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [15:0] max_duty_reg;
    gains_t      gains;

    // controller state
    logic [POS_WIDTH-1:0] cur_pos_reg, cur_pos_next;
    logic [POS_WIDTH-1:0] goal_pos_reg, goal_pos_next;
    logic [POS_WIDTH-1:0] last_error_reg, last_error_next;
    logic [SUM_WIDTH-1:0] error_sum_reg, error_sum_next;
    logic [15:0]          drive_duty_reg, drive_duty_next;
    logic [1:0]           drive_dir_reg, drive_dir_next;

    // error computation for a control tick
    logic [POS_WIDTH-1:0] err, dmag;
    logic [1:0]           dir;
    logic                 dneg;
    logic [SUM_WIDTH-1:0] sum_base, sum_tick;
    logic [SUM_WIDTH:0]   sum_add;

    // stage 1 and output stage
    logic  accept;
    logic  v1_reg, rdy1;
    op_t   op_next, op1_reg;
    logic  mac_ready, mac_valid;
    acc_t  mac_data;
    logic  v6_reg, rdy6, load6;
    logic [31:0] pos6_reg, err6_reg;
    logic [63:0] acc_abs;
    logic [47:0] mag;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            max_duty_reg <= MAX_DUTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP:         kp_reg       <= cfg_wdata;
                CFG_KI_DT:      ki_reg       <= cfg_wdata;
                CFG_KD_OVER_DT: kd_reg       <= cfg_wdata;
                CFG_MAX_DUTY:   max_duty_reg <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    assign gains.kp = kp_reg;
    assign gains.ki = ki_reg;
    assign gains.kd = kd_reg;

    // ------------------------------------------------------------------
    // handshake chain: a stage loads when empty or when its successor loads
    // ------------------------------------------------------------------
    assign rdy6      = !v6_reg || rsp.ready;
    assign rdy1      = !v1_reg || mac_ready;
    assign req.ready = rdy1;
    assign accept    = req.valid && rdy1;
    assign load6     = rdy6 && mac_valid;

    // ------------------------------------------------------------------
    // error, direction and integral, taken against the state of this cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_base = error_sum_reg;
        if (goal_pos_reg > cur_pos_reg)
        begin
            dir = DIR_UP;
            err = goal_pos_reg - cur_pos_reg;
        end
        else if (goal_pos_reg < cur_pos_reg)
        begin
            dir = DIR_DOWN;
            err = cur_pos_reg - goal_pos_reg;
        end
        else
        begin
            // at the target the integral is dropped
            dir      = DIR_STOP;
            err      = '0;
            sum_base = '0;
        end

        // integrate only errors outside the deadband, saturating
        sum_add = {1'b0, sum_base} + (SUM_WIDTH + 1)'(err);
        if (err > POS_WIDTH'(DEADBAND))
            sum_tick = sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
        else
            sum_tick = sum_base;

        dneg = err < last_error_reg;
        dmag = dneg ? (last_error_reg - err) : (err - last_error_reg);
    end

    always_comb
    begin
        cur_pos_next    = cur_pos_reg;
        goal_pos_next   = goal_pos_reg;
        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;

        case (req.cmd)
            CMD_STEP:
            begin
                case (req.step_dir)
                    DIR_UP:   cur_pos_next = cur_pos_reg + POS_WIDTH'(1);
                    DIR_DOWN: cur_pos_next = cur_pos_reg - POS_WIDTH'(1);
                    default:  ;
                endcase
            end
            CMD_TARGET: goal_pos_next = req.target[POS_WIDTH-1:0];
            CMD_TICK:
            begin
                last_error_next = err;
                error_sum_next  = sum_tick;
            end
            default: ;
        endcase

        op_next.meta.is_tick   = (req.cmd == CMD_TICK);
        op_next.meta.dir       = dir;
        op_next.meta.err_lt_db = err < POS_WIDTH'(DEADBAND);
        op_next.meta.pos       = POS_W_MAX'(cur_pos_next);
        op_next.meta.err_mag   = POS_W_MAX'(last_error_next);
        op_next.err            = POS_W_MAX'(err);
        op_next.dmag           = POS_W_MAX'(dmag);
        op_next.dneg           = dneg;
        op_next.sum            = SUM_W_MAX'(sum_tick);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg    <= '0;
            goal_pos_reg   <= '0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            v1_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_pos_reg    <= cur_pos_next;
                goal_pos_reg   <= goal_pos_next;
                last_error_reg <= last_error_next;
                error_sum_reg  <= error_sum_next;
            end
            if (rdy1)
                v1_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op1_reg <= op_next;
    end

    // ------------------------------------------------------------------
    // gain products and sum
    // ------------------------------------------------------------------
    pidpm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains),
        .in_valid  (v1_reg),
        .in_ready  (mac_ready),
        .in_op     (op1_reg),
        .out_valid (mac_valid),
        .out_ready (rdy6),
        .out_data  (mac_data)
    );

    // ------------------------------------------------------------------
    // duty limit and deadband; drive state only moves on a control tick
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_abs         = mac_data.acc[63] ? (~mac_data.acc + 64'd1) : mac_data.acc;
        mag             = acc_abs[63:16];
        drive_duty_next = drive_duty_reg;
        drive_dir_next  = drive_dir_reg;
        if (mac_data.meta.is_tick)
        begin
            if (mag > 48'(max_duty_reg))
            begin
                drive_duty_next = max_duty_reg;
                drive_dir_next  = mac_data.meta.dir;
            end
            else if (mac_data.meta.err_lt_db || mag < 48'(DEADBAND))
            begin
                drive_duty_next = '0;
                drive_dir_next  = DIR_STOP;
            end
            else
            begin
                drive_duty_next = mag[15:0];
                drive_dir_next  = mac_data.meta.dir;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg         <= 1'b0;
            drive_duty_reg <= '0;
            drive_dir_reg  <= DIR_UP;
        end
        else
        begin
            if (rdy6)
                v6_reg <= mac_valid;
            if (load6)
            begin
                drive_duty_reg <= drive_duty_next;
                drive_dir_reg  <= drive_dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load6)
        begin
            pos6_reg <= mac_data.meta.pos;
            err6_reg <= mac_data.meta.err_mag;
        end
    end

    assign rsp.valid     = v6_reg;
    assign rsp.duty      = drive_duty_reg;
    assign rsp.direction = drive_dir_reg;
    assign rsp.position  = pos6_reg;
    assign rsp.error_mag = err6_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_step_up: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd == CMD_STEP && req.step_dir == DIR_UP
        |=> cur_pos_reg == $past(cur_pos_reg) + POS_WIDTH'(1))
        else $error("position did not advance on an up step");

    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd == CMD_TICK && goal_pos_reg == cur_pos_reg
        |=> error_sum_reg == '0)
        else $error("integral not cleared at the target");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.cmd != CMD_TICK |=> $stable(last_error_reg))
        else $error("error changed on an item that is not a control tick");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid && !rsp.ready)
        else $error("input stalled while the output is not held");

endmodule
`default_nettype wire

// ----- hw/rtl/pidpm_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pidpm_mac
// pipelined gain multiply, saturation and sum of the three pid terms
// ----------------------------------------------------------------------------
module pidpm_mac
    import pidpm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire gains_t gains,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire op_t    in_op,
    output logic        out_valid,
    input  wire logic   out_ready,
    output acc_t        out_data
);

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    // stage 2: partial products
    meta_t       meta2_reg;
    logic [63:0] p_lo2_reg, d_lo2_reg, i_lo2_reg, i_hi2_reg;
    logic        p_neg2_reg, d_neg2_reg, i_neg2_reg;
    logic [31:0] ga_p, ga_d, ga_i;
    logic [63:0] p_lo_next, d_lo_next, i_lo_next, i_hi_next;

    // stage 3: clamped signed terms
    meta_t       meta3_reg;
    logic [63:0] p3_reg, d3_reg, i3_reg;

    // stage 4: first sum
    meta_t       meta4_reg;
    logic [63:0] a4_reg, i4_reg;

    // stage 5: full sum
    meta_t       meta5_reg;
    logic [63:0] acc5_reg;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_comb
    begin
        ga_p      = abs32(gains.kp);
        ga_d      = abs32(gains.kd);
        ga_i      = abs32(gains.ki);
        p_lo_next = 64'(ga_p) * 64'(in_op.err);
        d_lo_next = 64'(ga_d) * 64'(in_op.dmag);
        i_lo_next = 64'(ga_i) * 64'(in_op.sum[31:0]);
        i_hi_next = 64'(ga_i) * 64'(in_op.sum[63:32]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                v2_reg <= in_valid;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && in_valid)
        begin
            meta2_reg  <= in_op.meta;
            p_lo2_reg  <= p_lo_next;
            d_lo2_reg  <= d_lo_next;
            i_lo2_reg  <= i_lo_next;
            i_hi2_reg  <= i_hi_next;
            p_neg2_reg <= gains.kp[31];
            d_neg2_reg <= gains.kd[31] ^ in_op.dneg;
            i_neg2_reg <= gains.ki[31];
        end
        if (rdy3 && v2_reg)
        begin
            meta3_reg <= meta2_reg;
            p3_reg    <= sat_finish(p_lo2_reg, 64'd0, p_neg2_reg);
            d3_reg    <= sat_finish(d_lo2_reg, 64'd0, d_neg2_reg);
            i3_reg    <= sat_finish(i_lo2_reg, i_hi2_reg, i_neg2_reg);
        end
        if (rdy4 && v3_reg)
        begin
            meta4_reg <= meta3_reg;
            a4_reg    <= sat_add(p3_reg, d3_reg);
            i4_reg    <= i3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            meta5_reg <= meta4_reg;
            acc5_reg  <= sat_add(a4_reg, i4_reg);
        end
    end

    assign out_valid     = v5_reg;
    assign out_data.meta = meta5_reg;
    assign out_data.acc  = acc5_reg;

endmodule
`default_nettype wire
